[hw/rtl/jss_pkg.sv]
package jss_pkg;

   localparam int MAX_JOBS_DEF = 32;
   localparam int JOB_ID_W     = 8;
   localparam int DEADLINE_W   = 8;
   localparam int PROFIT_W     = 16;
   localparam int SLOT_W       = 5;

   // one stored job
   typedef struct packed {
      logic [JOB_ID_W-1:0]   job_id;
      logic [DEADLINE_W-1:0] deadline;
      logic [PROFIT_W-1:0]   profit;
   } job_entry_type;

   // sequencer -> slot search
   typedef struct packed {
      logic start;
      logic clear;
   } slot_cmd_type;

   // slot search -> sequencer
   typedef struct packed {
      logic              done;
      logic              found;
      logic [SLOT_W-1:0] slot;
   } slot_res_type;

endpackage

[hw/rtl/jss_if.sv]
interface jss_req_if import jss_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [JOB_ID_W-1:0]   job_id;
   logic [DEADLINE_W-1:0] deadline;
   logic [PROFIT_W-1:0]   profit;
   logic                  last_job;

   modport source (output valid, job_id, deadline, profit, last_job, input ready);
   modport sink   (input valid, job_id, deadline, profit, last_job, output ready);
endinterface

interface jss_rsp_if import jss_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [JOB_ID_W-1:0] out_job_id;
   logic                scheduled;
   logic [SLOT_W-1:0]   slot_index;
   logic                last_result;

   modport source (output valid, out_job_id, scheduled, slot_index, last_result,
                   input ready);
   modport sink   (input valid, out_job_id, scheduled, slot_index, last_result,
                   output ready);
endinterface

[hw/rtl/jss_job_mem.sv]
// Job store: one write port, one read port, registered read data.
// Loads and scans never overlap, so no forwarding is needed.
module jss_job_mem import jss_pkg::*; #(
   parameter int DEPTH = MAX_JOBS_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  job_entry_type wr_data,
   input  logic [AW-1:0] rd_addr,
   output job_entry_type rd_data
);

   job_entry_type mem_ff [DEPTH];
   job_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/jss_slot_search.sv]
// Latest-free-slot search: walks down from limit-1 one slot per cycle.
module jss_slot_search import jss_pkg::*; #(
   parameter int SLOTS = MAX_JOBS_DEF,
   parameter int AW    = $clog2(SLOTS),
   parameter int CW    = $clog2(SLOTS + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  slot_cmd_type  cmd,
   input  logic [CW-1:0] limit,
   output slot_res_type  res
);

   logic [SLOTS-1:0]  map_ff, map_in;
   logic [CW-1:0]     lim_ff, lim_in;
   logic              act_ff, act_in;
   logic              done_ff, done_in;
   logic              found_ff, found_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [AW-1:0]     probe;

   assign probe = AW'(lim_ff - CW'(1));

   always_comb begin
      map_in   = map_ff;
      lim_in   = lim_ff;
      act_in   = act_ff;
      done_in  = 1'b0;
      found_in = found_ff;
      slot_in  = slot_ff;
      if (cmd.clear) begin
         map_in = '0;
      end
      if (cmd.start) begin
         lim_in   = limit;
         act_in   = 1'b1;
         found_in = 1'b0;
         slot_in  = '0;
      end else if (act_ff) begin
         if (lim_ff == '0) begin
            act_in  = 1'b0;
            done_in = 1'b1;
         end else if (!map_ff[probe]) begin
            map_in[probe] = 1'b1;
            act_in        = 1'b0;
            done_in       = 1'b1;
            found_in      = 1'b1;
            slot_in       = SLOT_W'(probe);   // masked to the output width
         end else begin
            lim_in = lim_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_ff  <= '0;
         act_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         map_ff  <= map_in;
         act_ff  <= act_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      lim_ff   <= lim_in;
      found_ff <= found_in;
      slot_ff  <= slot_in;
   end

   assign res.done  = done_ff;
   assign res.found = found_ff;
   assign res.slot  = slot_ff;

endmodule

[hw/rtl/job_sequencing_deadline_scheduler.sv]
// Channel | Dir | Word                                           | Accept
// req_ch  | in  | job_id, deadline, profit, last_job             | valid & ready
// rsp_ch  | out | out_job_id, scheduled, slot_index, last_result | valid & ready
//
// Loading accepts job words while req_ch.ready is high. A word with last_job closes the batch;
// req_ch.ready then stays low until the last result has been handed to the
// output register. Each of the n results takes a memory scan of the batch (one
// read port, one job per cycle), a slot walk from below min(deadline, n) (one
// slot per cycle) and an emit into the output register.
// A stalled rsp_ch holds its word while the next scan runs; reset clears batch
// count, slot map and rsp_ch.valid at once and returns to loading.
module job_sequencing_deadline_scheduler import jss_pkg::*; #(
   parameter int MAX_JOBS = MAX_JOBS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   jss_req_if.sink   req_ch,
   jss_rsp_if.source rsp_ch
);

   localparam int AW = $clog2(MAX_JOBS);
   localparam int CW = $clog2(MAX_JOBS + 1);

   localparam logic [2:0] ST_LOAD   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_DRAIN  = 3'd2;
   localparam logic [2:0] ST_START  = 3'd3;
   localparam logic [2:0] ST_SEARCH = 3'd4;
   localparam logic [2:0] ST_EMIT   = 3'd5;

   logic [2:0]            state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;   // jobs in batch (n)
   logic [CW-1:0]         rank_ff, rank_in;     // results emitted so far
   logic [AW-1:0]         addr_ff, addr_in;     // scan read address
   logic                  dv_ff, dv_in;         // read data valid next cycle
   logic [AW-1:0]         dv_idx_ff, dv_idx_in;
   logic [MAX_JOBS-1:0]   taken_ff, taken_in;   // job already emitted
   logic                  have_ff, have_in;
   logic [AW-1:0]         best_idx_ff, best_idx_in;
   logic [PROFIT_W-1:0]   best_prof_ff, best_prof_in;
   logic [JOB_ID_W-1:0]   best_id_ff, best_id_in;
   logic [DEADLINE_W-1:0] best_dl_ff, best_dl_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [JOB_ID_W-1:0]   rsp_id_ff, rsp_id_in;
   logic                  rsp_sched_ff, rsp_sched_in;
   logic [SLOT_W-1:0]     rsp_slot_ff, rsp_slot_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  req_acc;
   logic                  mem_we;
   job_entry_type         mem_wdata;
   job_entry_type         mem_rdata;
   slot_cmd_type          slot_cmd;
   slot_res_type          slot_res;
   logic [CW-1:0]         slot_limit;
   logic [CW-1:0]         last_pos;
   logic                  out_free;

   assign req_ch.ready = (state_ff == ST_LOAD);
   assign req_acc      = req_ch.valid && req_ch.ready;
   // a full batch drops the word but still honors last_job
   assign mem_we       = req_acc && (count_ff < CW'(MAX_JOBS));
   assign mem_wdata    = '{job_id: req_ch.job_id, deadline: req_ch.deadline,
                           profit: req_ch.profit};
   assign last_pos     = count_ff - CW'(1);
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   // search starts below min(deadline, n)
   assign slot_limit   = (best_dl_ff > DEADLINE_W'(count_ff)) ? count_ff
                                                               : CW'(best_dl_ff);

   jss_job_mem #(.DEPTH(MAX_JOBS), .AW(AW)) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (mem_wdata),
      .rd_addr (addr_ff),
      .rd_data (mem_rdata)
   );

   jss_slot_search #(.SLOTS(MAX_JOBS), .AW(AW), .CW(CW)) u_slot (
      .clock (clock),
      .reset (reset),
      .cmd   (slot_cmd),
      .limit (slot_limit),
      .res   (slot_res)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rank_in      = rank_ff;
      addr_in      = addr_ff;
      dv_in        = 1'b0;
      dv_idx_in    = addr_ff;
      taken_in     = taken_ff;
      have_in      = have_ff;
      best_idx_in  = best_idx_ff;
      best_prof_in = best_prof_ff;
      best_id_in   = best_id_ff;
      best_dl_in   = best_dl_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_id_in    = rsp_id_ff;
      rsp_sched_in = rsp_sched_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_last_in  = rsp_last_ff;
      slot_cmd     = '{start: 1'b0, clear: 1'b0};

      // max-profit pick; strict compare keeps the earliest of equal profits
      if (dv_ff && !taken_ff[dv_idx_ff] && (!have_ff || mem_rdata.profit > best_prof_ff))
      begin
         have_in      = 1'b1;
         best_idx_in  = dv_idx_ff;
         best_prof_in = mem_rdata.profit;
         best_id_in   = mem_rdata.job_id;
         best_dl_in   = mem_rdata.deadline;
      end

      unique case (state_ff)
         ST_LOAD: begin
            if (mem_we) begin
               count_in = count_ff + CW'(1);
            end
            if (req_acc && req_ch.last_job) begin
               state_in = ST_SCAN;
               addr_in  = '0;
               have_in  = 1'b0;
               rank_in  = '0;
            end
         end
         ST_SCAN: begin
            dv_in = 1'b1;
            if (addr_ff == AW'(last_pos)) begin
               state_in = ST_DRAIN;
            end else begin
               addr_in = addr_ff + AW'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_START;
         end
         ST_START: begin
            slot_cmd.start = 1'b1;
            state_in       = ST_SEARCH;
         end
         ST_SEARCH: begin
            if (slot_res.done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_id_in             = best_id_ff;
               rsp_sched_in          = slot_res.found;
               rsp_slot_in           = slot_res.found ? slot_res.slot : '0;
               rsp_last_in           = (rank_ff == last_pos);
               taken_in[best_idx_ff] = 1'b1;
               rank_in               = rank_ff + CW'(1);
               addr_in               = '0;
               have_in               = 1'b0;
               if (rank_ff == last_pos) begin
                  // batch end: free every slot and empty the store
                  slot_cmd.clear = 1'b1;
                  count_in       = '0;
                  taken_in       = '0;
                  state_in       = ST_LOAD;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         rank_ff      <= '0;
         dv_ff        <= 1'b0;
         taken_ff     <= '0;
         have_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rank_ff      <= rank_in;
         dv_ff        <= dv_in;
         taken_ff     <= taken_in;
         have_ff      <= have_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff      <= addr_in;
      dv_idx_ff    <= dv_idx_in;
      best_idx_ff  <= best_idx_in;
      best_prof_ff <= best_prof_in;
      best_id_ff   <= best_id_in;
      best_dl_ff   <= best_dl_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_sched_ff <= rsp_sched_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.out_job_id  = rsp_id_ff;
   assign rsp_ch.scheduled   = rsp_sched_ff;
   assign rsp_ch.slot_index  = rsp_slot_ff;
   assign rsp_ch.last_result = rsp_last_ff;

endmodule

[hw/rtl/jss_checker.sv]
module jss_checker import jss_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                req_last_job,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [JOB_ID_W-1:0] rsp_out_job_id,
   input logic                rsp_scheduled,
   input logic [SLOT_W-1:0]   rsp_slot_index,
   input logic                rsp_last_result
);

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_job_id)
         && $stable(rsp_scheduled) && $stable(rsp_slot_index)
         && $stable(rsp_last_result))
      else $error("rsp word changed while stalled");

   // rejected jobs report slot zero
   a_unsched_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_scheduled |-> rsp_slot_index == '0)
      else $error("unscheduled job with nonzero slot");

   // closing word stops loading
   a_close_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last_job |=> !req_ready)
      else $error("input still ready after batch close");

   // mid-batch result means no loading
   a_mid_batch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_result |-> !req_ready)
      else $error("input ready while batch results pending");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind job_sequencing_deadline_scheduler jss_checker u_jss_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .req_last_job    (req_ch.last_job),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_out_job_id  (rsp_ch.out_job_id),
   .rsp_scheduled   (rsp_ch.scheduled),
   .rsp_slot_index  (rsp_ch.slot_index),
   .rsp_last_result (rsp_ch.last_result)
);

[tb/sv/job_sequencing_deadline_scheduler_test.sv]
`timescale 1ns / 100ps

// Job sequencing scheduler bench: a word-by-word driver on req_ch, a random-stall
// sink on rsp_ch, and a greedy scheduler predictor fed at each accepted job word.
module job_sequencing_deadline_scheduler_test;
   import jss_pkg::*;

   localparam int JOB_CAP    = MAX_JOBS_DEF;
   localparam int RAND_ITEMS = 450;
   localparam int DRAIN      = 100;
   // Worst run here is far below this even if every batch were full and stalled.
   localparam int LIMIT      = 1000000;
   localparam int MISS_SHOW  = 10;

   // one job word as driven on req_ch
   typedef struct packed {
      logic [JOB_ID_W-1:0]   job_id;
      logic [DEADLINE_W-1:0] deadline;
      logic [PROFIT_W-1:0]   profit;
      logic                  last_job;
   } job_word_type;

   // one result word as seen on rsp_ch
   typedef struct packed {
      logic [JOB_ID_W-1:0] job_id;
      logic                scheduled;
      logic [SLOT_W-1:0]   slot;
      logic                last;
   } slot_result_type;

   // Directed row: driven reps times with job_id + i and profit + (i & 3).
   // last_job goes on the final repeat only. Typed rows are one-job batches
   // whose single result is written here rather than predicted.
   typedef struct packed {
      logic [JOB_ID_W-1:0]   job_id;
      logic [DEADLINE_W-1:0] deadline;
      logic [PROFIT_W-1:0]   profit;
      logic                  last_job;
      logic [6:0]            reps;
      logic                  typed;
      logic                  exp_sched;
      logic [SLOT_W-1:0]     exp_slot;
   } directed_row_type;

   localparam int NUM_ROWS = 15;

   directed_row_type directed_rows [NUM_ROWS] = '{
      // zero deadline, straight after reset: rejected
      '{8'hFF, 8'h00, 16'h0000, 1'b1, 7'd1, 1'b1, 1'b0, 5'd0},
      // deadline far beyond count, top profit: clamped to slot 0
      '{8'h00, 8'hFF, 16'hFFFF, 1'b1, 7'd1, 1'b1, 1'b1, 5'd0},
      // deadline one: slot 0
      '{8'h5A, 8'h01, 16'hA5A5, 1'b1, 7'd1, 1'b1, 1'b1, 5'd0},
      // equal profits keep load order; two get pushed out
      '{8'h10, 8'h02, 16'h1234, 1'b0, 7'd1, 1'b0, 1'b0, 5'd0},
      '{8'h11, 8'h02, 16'h1234, 1'b0, 7'd1, 1'b0, 1'b0, 5'd0},
      '{8'h12, 8'h02, 16'h1234, 1'b0, 7'd1, 1'b0, 1'b0, 5'd0},
      '{8'h13, 8'h01, 16'h1234, 1'b1, 7'd1, 1'b0, 1'b0, 5'd0},
      // mixed profits, slot conflicts, a zero deadline inside a batch
      '{8'h20, 8'h03, 16'h0001, 1'b0, 7'd1, 1'b0, 1'b0, 5'd0},
      '{8'h21, 8'h03, 16'hFFFF, 1'b0, 7'd1, 1'b0, 1'b0, 5'd0},
      '{8'h22, 8'h01, 16'h8000, 1'b0, 7'd1, 1'b0, 1'b0, 5'd0},
      '{8'h23, 8'h00, 16'h7FFF, 1'b0, 7'd1, 1'b0, 1'b0, 5'd0},
      '{8'h24, 8'h09, 16'h0000, 1'b1, 7'd1, 1'b0, 1'b0, 5'd0},
      // batch full: 32 stored, two more dropped, the dropped closer still closes the batch
      '{8'h40, 8'h20, 16'h4000, 1'b0, 7'd33, 1'b0, 1'b0, 5'd0},
      '{8'hC0, 8'h05, 16'hFFFF, 1'b1, 7'd1, 1'b0, 1'b0, 5'd0},
      // lone job right after a full batch, deadline past the count
      '{8'hE0, 8'h1F, 16'h0200, 1'b1, 7'd1, 1'b0, 1'b0, 5'd0}
   };

   logic clock;
   logic reset;

   jss_req_if req_ch ();
   jss_rsp_if rsp_ch ();

   job_sequencing_deadline_scheduler #(
      .MAX_JOBS(JOB_CAP)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   // predictor state: the batch being loaded and the slot map
   job_entry_type     held_jobs [JOB_CAP];
   int unsigned       held_count = 0;
   logic [JOB_CAP-1:0] slot_busy = '0;

   // results owed by the block, oldest first
   slot_result_type   due_results [$];

   int unsigned miss_count = 0;
   int          idle_pct   = 0;   // sender idle chance per word, percent
   int          stall_pct  = 0;   // receiver stall chance per cycle, percent

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Predictor: load one accepted job word, and on last_job run the greedy
   // schedule over the held batch and queue one result per held job.
   task automatic book_job(input job_word_type w);
      int unsigned     order [JOB_CAP];
      int unsigned     n;
      int unsigned     k;
      int unsigned     idx;
      int unsigned     lim;
      int unsigned     slot;
      bit              got;
      slot_result_type r;
      if (held_count < JOB_CAP) begin
         held_jobs[held_count] = '{job_id: w.job_id, deadline: w.deadline,
                                   profit: w.profit};
         held_count++;
      end
      if (w.last_job) begin
         n = held_count;
         // stable insertion sort, highest profit first
         for (int i = 0; i < n; i++) begin
            k = i;
            while (k > 0 && held_jobs[order[k-1]].profit < held_jobs[i].profit) begin
               order[k] = order[k-1];
               k--;
            end
            order[k] = i;
         end
         for (int i = 0; i < n; i++) begin
            idx = order[i];
            lim = held_jobs[idx].deadline;
            if (lim > n) lim = n;
            got  = 1'b0;
            slot = 0;
            // latest free slot below the clamped deadline
            while (lim > 0 && !got) begin
               lim--;
               if (!slot_busy[lim]) begin
                  slot_busy[lim] = 1'b1;
                  got  = 1'b1;
                  slot = lim;
               end
            end
            r.job_id    = held_jobs[idx].job_id;
            r.scheduled = got;
            r.slot      = slot[SLOT_W-1:0];
            r.last      = (i + 1 == n);
            due_results.push_back(r);
         end
         slot_busy  = '0;
         held_count = 0;
      end
   endtask

   // Present one job word, idling first at the phase's rate, and hold it
   // until accepted. Valid gets exactly one assignment per time step.
   task automatic send_job(input job_word_type w);
      while ($urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.job_id   <= w.job_id;
      req_ch.deadline <= w.deadline;
      req_ch.profit   <= w.profit;
      req_ch.last_job <= w.last_job;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      book_job(w);
   endtask

   // receiver: random stall per cycle
   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
   end

   // result checker: every accepted rsp word against the oldest expectation
   always @(posedge clock) begin : rsp_check
      slot_result_type got_res;
      slot_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got_res = '{job_id: rsp_ch.out_job_id, scheduled: rsp_ch.scheduled,
                     slot: rsp_ch.slot_index, last: rsp_ch.last_result};
         if (due_results.size() == 0) begin
            miss_count++;
            if (miss_count <= MISS_SHOW)
               $display("unexpected rsp word: id %0h sched %0b slot %0d last %0b",
                        got_res.job_id, got_res.scheduled, got_res.slot, got_res.last);
         end else begin
            want = due_results.pop_front();
            if (got_res.job_id !== want.job_id || got_res.scheduled !== want.scheduled ||
                got_res.slot !== want.slot || got_res.last !== want.last) begin
               miss_count++;
               if (miss_count <= MISS_SHOW)
                  $display("rsp mismatch: want id %0h sched %0b slot %0d last %0b, %s",
                           want.job_id, want.scheduled, want.slot, want.last,
                           $sformatf("got id %0h sched %0b slot %0d last %0b",
                                     got_res.job_id, got_res.scheduled,
                                     got_res.slot, got_res.last));
            end
         end
      end
   end

   // watchdog
   initial begin
      repeat (LIMIT) @(posedge clock);
      $display("job_sequencing_deadline_scheduler test failed");
      $finish;
   end

   initial begin : stimulus
      job_word_type    w;
      slot_result_type typed_res;
      int unsigned     rand_items;
      int unsigned     n;
      int unsigned     pick;
      int unsigned     phase;
      bit              tie_mode;

      req_ch.valid    <= 1'b0;
      req_ch.job_id   <= '0;
      req_ch.deadline <= '0;
      req_ch.profit   <= '0;
      req_ch.last_job <= 1'b0;
      reset           <= 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // ---- directed table, no idling ----
      foreach (directed_rows[r]) begin
         for (int i = 0; i < directed_rows[r].reps; i++) begin
            w.job_id   = JOB_ID_W'(directed_rows[r].job_id + i);
            w.deadline = directed_rows[r].deadline;
            w.profit   = PROFIT_W'(directed_rows[r].profit + (i & 3));
            w.last_job = directed_rows[r].last_job && (i == directed_rows[r].reps - 1);
            send_job(w);
         end
         if (directed_rows[r].typed) begin
            // the typed result stands in for the one just predicted
            typed_res = '{job_id: directed_rows[r].job_id,
                          scheduled: directed_rows[r].exp_sched,
                          slot: directed_rows[r].exp_slot, last: 1'b1};
            void'(due_results.pop_back());
            due_results.push_back(typed_res);
         end
      end

      // ---- random batches, four idling phases ----
      rand_items = 0;
      while (rand_items < RAND_ITEMS) begin
         phase = rand_items * 4 / RAND_ITEMS;
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 78; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 78; end
            default: begin idle_pct = 7; stall_pct = 7; end
         endcase
         // mostly small batches; a few full, a few that overflow
         pick = $urandom_range(99);
         if (pick < 70)      n = $urandom_range(1, 6);
         else if (pick < 90) n = $urandom_range(7, 16);
         else if (pick < 97) n = $urandom_range(17, JOB_CAP);
         else                n = $urandom_range(JOB_CAP + 1, JOB_CAP + 4);
         tie_mode = 1'($urandom_range(1));
         for (int j = 0; j < n; j++) begin
            w.job_id = JOB_ID_W'($urandom_range(255));
            pick = $urandom_range(9);
            if (pick == 0)      w.deadline = 8'h00;
            else if (pick == 1) w.deadline = 8'hFF;
            else if (pick < 7)
               w.deadline = DEADLINE_W'($urandom_range(1,
                                        (n < JOB_CAP ? n : JOB_CAP) + 1));
            else                w.deadline = DEADLINE_W'($urandom_range(255));
            if (tie_mode) begin
               // few distinct profits so ties are common
               case ($urandom_range(3))
                  0: w.profit = 16'h0000;
                  1: w.profit = 16'hFFFF;
                  2: w.profit = 16'h8000;
                  default: w.profit = 16'h7FFF;
               endcase
            end else begin
               w.profit = PROFIT_W'($urandom_range(65535));
            end
            w.last_job = (j == n - 1);
            send_job(w);
            // dropped words that do not close a batch are ignored by the block
            if (j < JOB_CAP || w.last_job) rand_items++;
         end
      end
      req_ch.valid <= 1'b0;

      while (due_results.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);

      if (miss_count == 0 && due_results.size() == 0) begin
         $display("job_sequencing_deadline_scheduler test passed");
      end else begin
         $display("job_sequencing_deadline_scheduler test failed");
      end
      $finish;
   end

endmodule

[job_sequencing_deadline_scheduler.f]
hw/rtl/jss_pkg.sv
hw/rtl/jss_if.sv
hw/rtl/jss_job_mem.sv
hw/rtl/jss_slot_search.sv
hw/rtl/job_sequencing_deadline_scheduler.sv
hw/rtl/jss_checker.sv
tb/sv/job_sequencing_deadline_scheduler_test.sv
